FILE: hdl/mbtc_pkg.sv
package mbtc_pkg;

  // Field widths of the transactions.
  localparam int UTC_W    = 40;
  localparam int MJD_W    = 16;
  localparam int EPOCH_W  = 33;
  localparam int OUT_W    = 80;

  // Total register stages from input to output register.
  localparam int PIPE_DEPTH = 8;
  // The time path finishes after three stages and is delayed to match the date path.
  localparam int TIME_DLY   = PIPE_DEPTH - 3;

  // First MJD for which the calendar formulas hold.
  localparam logic [MJD_W-1:0] MJD_FIRST_VALID = 16'd15079;
  // MJD of 1970-01-01.
  localparam logic signed [16:0] MJD_UNIX_EPOCH = 17'sd40587;

  // Year estimate: floor((20*MJD - 301564) / 7305).
  localparam logic [19:0] YEAR_OFFSET = 20'd301564;
  localparam logic [12:0] YEAR_DIV    = 13'd7305;
  localparam int          YEAR_SHIFT  = 32;
  localparam logic [19:0] YEAR_RECIP  = 20'((64'd1 << YEAR_SHIFT) / 64'd7305);

  // Month estimate: floor((10000*X - 1000) / 306001).
  localparam logic [18:0] MONTH_DIV   = 19'd306001;
  localparam int          MONTH_SHIFT = 40;
  localparam logic [21:0] MONTH_RECIP = 22'((64'd1 << MONTH_SHIFT) / 64'd306001);

  localparam logic [16:0] DAY_OFFSET  = 17'd14956;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic       out_of_range;
  } mbtc_date_t;

  typedef struct packed {
    logic [7:0]                hour;
    logic [7:0]                minute;
    logic [7:0]                second;
    logic signed [EPOCH_W-1:0] epoch;
  } mbtc_time_t;

  // floor(30.6001 * m), the day count up to the start of month estimate m.
  function automatic logic [9:0] month_days(input logic [5:0] m);
    logic [9:0] d;
    case (m)
      6'd1:    d = 10'd30;
      6'd2:    d = 10'd61;
      6'd3:    d = 10'd91;
      6'd4:    d = 10'd122;
      6'd5:    d = 10'd153;
      6'd6:    d = 10'd183;
      6'd7:    d = 10'd214;
      6'd8:    d = 10'd244;
      6'd9:    d = 10'd275;
      6'd10:   d = 10'd306;
      6'd11:   d = 10'd336;
      6'd12:   d = 10'd367;
      6'd13:   d = 10'd397;
      6'd14:   d = 10'd428;
      6'd15:   d = 10'd459;
      default: d = 10'd0;
    endcase
    return d;
  endfunction

  // Two BCD digits to binary, digits unchecked.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]};
    return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
  endfunction

endpackage

FILE: hdl/mbtc_date_pipe.sv
module mbtc_date_pipe (
  input  logic                    clk,
  input  logic                    ce,
  input  logic [15:0]             mjd,
  output mbtc_pkg::mbtc_date_t    date
);
  import mbtc_pkg::*;

  // Stage 1: scaled numerator of the year estimate and range flag.
  logic [MJD_W-1:0] mjd1_r;
  logic [19:0]      n1_r;
  logic             oor1_r;
  logic [19:0]      n1_nxt;

  assign n1_nxt = (20'(mjd) << 4) + (20'(mjd) << 2) - YEAR_OFFSET;

  // Stage 2: reciprocal multiply gives the year quotient or one less.
  logic [MJD_W-1:0] mjd2_r;
  logic [19:0]      n2_r;
  logic [7:0]       q2_r;
  logic             oor2_r;
  logic [39:0]      yprod;

  assign yprod = 40'(n1_r) * 40'(YEAR_RECIP);

  // Stage 3: remainder check fixes the year quotient.
  logic [MJD_W-1:0] mjd3_r;
  logic [7:0]       yp3_r;
  logic             oor3_r;
  logic [20:0]      yrem;
  logic [7:0]       yp3_nxt;

  assign yrem    = 21'(n2_r) - 21'(q2_r) * 21'(YEAR_DIV);
  assign yp3_nxt = q2_r + 8'(yrem >= 21'(YEAR_DIV));

  // Stage 4: day within the March-based year, X = MJD - 14956 - floor(365.25*Y').
  logic [7:0]  yp4_r;
  logic [9:0]  x4_r;
  logic        oor4_r;
  logic [18:0] aprod;
  logic [16:0] x4_full;

  assign aprod   = 19'(yp3_r) * 19'd1461;
  assign x4_full = 17'(mjd3_r) - DAY_OFFSET - aprod[18:2];

  // Stage 5: numerator of the month estimate.
  logic [7:0]  yp5_r;
  logic [9:0]  x5_r;
  logic [23:0] n5_r;
  logic        oor5_r;
  logic [23:0] n5_nxt;

  assign n5_nxt = 24'(x4_r) * 24'd10000 - 24'd1000;

  // Stage 6: reciprocal multiply gives the month quotient or one less.
  logic [7:0]  yp6_r;
  logic [9:0]  x6_r;
  logic [23:0] n6_r;
  logic [5:0]  q6_r;
  logic        oor6_r;
  logic [45:0] mprod;

  assign mprod = 46'(n5_r) * 46'(MONTH_RECIP);

  // Stage 7: remainder check fixes the month quotient.
  logic [7:0]  yp7_r;
  logic [9:0]  x7_r;
  logic [5:0]  mp7_r;
  logic        oor7_r;
  logic [24:0] mrem;
  logic [5:0]  mp7_nxt;

  assign mrem    = 25'(n6_r) - 25'(q6_r) * 25'(MONTH_DIV);
  assign mp7_nxt = q6_r + 6'(mrem >= 25'(MONTH_DIV));

  // Stage 8: month and day; January and February roll into the next year.
  mbtc_date_t date_r;
  mbtc_date_t date_nxt;
  logic       jan_feb;
  logic [9:0] day_full;

  always_comb begin
    jan_feb  = (mp7_r == 6'd14) || (mp7_r == 6'd15);
    day_full = x7_r - month_days(mp7_r);
    date_nxt.out_of_range = oor7_r;
    if (oor7_r) begin
      date_nxt.year  = '0;
      date_nxt.month = '0;
      date_nxt.day   = '0;
    end else begin
      date_nxt.year  = yp7_r + 8'(jan_feb);
      date_nxt.month = jan_feb ? 4'(mp7_r - 6'd13) : 4'(mp7_r - 6'd1);
      date_nxt.day   = day_full[4:0];
    end
  end

  // Pipeline registers, all held together while the output is stalled.
  always_ff @(posedge clk) begin
    if (ce) begin
      mjd1_r <= mjd;
      n1_r   <= n1_nxt;
      oor1_r <= (mjd < MJD_FIRST_VALID);

      mjd2_r <= mjd1_r;
      n2_r   <= n1_r;
      q2_r   <= yprod[YEAR_SHIFT+7:YEAR_SHIFT];
      oor2_r <= oor1_r;

      mjd3_r <= mjd2_r;
      yp3_r  <= yp3_nxt;
      oor3_r <= oor2_r;

      yp4_r  <= yp3_r;
      x4_r   <= x4_full[9:0];
      oor4_r <= oor3_r;

      yp5_r  <= yp4_r;
      x5_r   <= x4_r;
      n5_r   <= n5_nxt;
      oor5_r <= oor4_r;

      yp6_r  <= yp5_r;
      x6_r   <= x5_r;
      n6_r   <= n5_r;
      q6_r   <= mprod[MONTH_SHIFT+5:MONTH_SHIFT];
      oor6_r <= oor5_r;

      yp7_r  <= yp6_r;
      x7_r   <= x6_r;
      mp7_r  <= mp7_nxt;
      oor7_r <= oor6_r;

      date_r <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

FILE: hdl/mbtc_time_pipe.sv
module mbtc_time_pipe (
  input  logic                 clk,
  input  logic                 ce,
  input  logic [15:0]          mjd,
  input  logic [7:0]           hour_bcd,
  input  logic [7:0]           minute_bcd,
  input  logic [7:0]           second_bcd,
  output mbtc_pkg::mbtc_time_t tod
);
  import mbtc_pkg::*;

  // Stage 1: BCD decode and day offset from the Unix epoch.
  logic [7:0]        hh1_r, mm1_r, ss1_r;
  logic signed [16:0] dd1_r;

  // Stage 2: seconds of the days and seconds of the day.
  logic [7:0]         hh2_r, mm2_r, ss2_r;
  logic signed [33:0] dsec2_r;
  logic [19:0]        tsec2_r;
  logic signed [33:0] dsec_nxt;
  logic [19:0]        tsec_nxt;

  assign dsec_nxt = 34'(dd1_r) * 34'sd86400;
  assign tsec_nxt = 20'(hh1_r) * 20'd3600 + 20'(mm1_r) * 20'd60 + 20'(ss1_r);

  // Stage 3: epoch sum.
  mbtc_time_t         t3_nxt;
  logic signed [33:0] epoch_full;

  assign epoch_full   = dsec2_r + $signed({14'd0, tsec2_r});
  assign t3_nxt.hour   = hh2_r;
  assign t3_nxt.minute = mm2_r;
  assign t3_nxt.second = ss2_r;
  assign t3_nxt.epoch  = epoch_full[EPOCH_W-1:0];

  // Stages 4 onward: delay line that lines up with the date path.
  mbtc_time_t dly_r [TIME_DLY+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      hh1_r   <= bcd_to_bin(hour_bcd);
      mm1_r   <= bcd_to_bin(minute_bcd);
      ss1_r   <= bcd_to_bin(second_bcd);
      dd1_r   <= $signed({1'b0, mjd}) - MJD_UNIX_EPOCH;

      hh2_r   <= hh1_r;
      mm2_r   <= mm1_r;
      ss2_r   <= ss1_r;
      dsec2_r <= dsec_nxt;
      tsec2_r <= tsec_nxt;

      dly_r[0] <= t3_nxt;
      for (int i = 1; i <= TIME_DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign tod = dly_r[TIME_DLY];

endmodule

FILE: hdl/mjd_bcd_time_to_calendar_unit.sv
// Channel  Ports                        Payload
// -------  ---------------------------  ------------------------------------------
// input    in_tvalid/in_tready/in_tdata  40-bit UTC time: MJD, hour, minute, second
// output   out_tvalid/out_tready/        date, decoded time, epoch seconds;
//          out_tdata/out_tuser           tuser flags an MJD below the valid range
//
// The pipeline length from acceptance to the output register is set by the date
// path: two reciprocal divisions, each a multiply stage and a remainder-correction
// stage, a numerator stage before each, a day-of-year stage and a final day stage.
// A new transaction is accepted in every cycle while the output is empty or taken.
// When the output is stalled the whole pipeline holds; empty stages are not squeezed.
// Reset clears the valid bits only; the pipeline is empty after reset.
module mjd_bcd_time_to_calendar_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mbtc_pkg::UTC_W-1:0]   in_tdata,   // [7:0] second, [15:8] minute,
                                                   // [23:16] hour (BCD), [39:24] MJD
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mbtc_pkg::OUT_W-1:0]   out_tdata,  // [7:0] year_since_1900,
                                                   // [11:8] month_number,
                                                   // [16:12] day_of_month,
                                                   // [24:17] hour_value,
                                                   // [32:25] minute_value,
                                                   // [40:33] second_value,
                                                   // [73:41] epoch_seconds, [79:74] zero
  output logic                         out_tuser   // [0] out_of_range
);
  import mbtc_pkg::*;

  logic [PIPE_DEPTH-1:0] valid_r;
  logic [PIPE_DEPTH-1:0] valid_nxt;
  logic                  ce;
  mbtc_date_t            date;
  mbtc_time_t            tod;

  // The pipeline advances unless a finished transaction waits at the output.
  assign ce        = !valid_r[PIPE_DEPTH-1] || out_tready;
  assign in_tready = ce;
  assign valid_nxt = {valid_r[PIPE_DEPTH-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ce) begin
      valid_r <= valid_nxt;
    end
  end

  // Date and time paths run side by side with the same depth.
  mbtc_date_pipe u_date (
    .clk  (clk),
    .ce   (ce),
    .mjd  (in_tdata[39:24]),
    .date (date)
  );

  mbtc_time_pipe u_time (
    .clk        (clk),
    .ce         (ce),
    .mjd        (in_tdata[39:24]),
    .hour_bcd   (in_tdata[23:16]),
    .minute_bcd (in_tdata[15:8]),
    .second_bcd (in_tdata[7:0]),
    .tod        (tod)
  );

  // Output packing.
  assign out_tvalid = valid_r[PIPE_DEPTH-1];
  assign out_tuser  = date.out_of_range;
  assign out_tdata  = {6'd0, tod.epoch, tod.second, tod.minute, tod.hour,
                       date.day, date.month, date.year};

  // A stalled output freezes every stage of the pipeline.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(valid_r))
    else $error("pipeline moved while output stalled");

  // An out-of-range MJD zeroes the calendar fields.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (date.year == 8'd0 && date.month == 4'd0 && date.day == 5'd0))
    else $error("calendar fields not cleared for out-of-range MJD");

  // A valid MJD always yields a real month and day.
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (date.month >= 4'd1 && date.month <= 4'd12 && date.day >= 5'd1))
    else $error("calendar date out of legal range");

  // The pipeline is empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
